// ===== rtl/ctwr_pkg.sv =====
// Shared types and constants of the text console character writer.
// Used by the controller, the datapath and the top level; depends on nothing.

package ctwr_pkg;

  // Screen geometry and tab stops.
  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 50;
  localparam int TAB_WIDTH      = 4;
  localparam int MAX_RESULTS    = 4;
  localparam int STEP_W         = $clog2(MAX_RESULTS);

  // Field widths.
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int ADDR_W = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Character codes with a control meaning.
  localparam logic [CHAR_W-1:0] CHAR_NUL       = 8'd0;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'd32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_MAX_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_MAX_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTRIBUTE  = 3'd6;

  // What an accepted character asks of the write sequencer.
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_BACK  = 2'd1,
    OP_TAB   = 2'd2,
    OP_PRINT = 2'd3
  } op_e;

  // Controller to datapath.
  typedef struct packed {
    logic              load;
    logic              emit;
    logic [STEP_W-1:0] step;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_e  in_op;
    logic last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/ctwr_ctrl.sv =====
// Sequencing controller of the text console character writer.
// Depends on ctwr_pkg; drives the datapath through a command struct.

module ctwr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ctwr_pkg::status_t status_i,
  output ctwr_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  state_e                      state_q, state_d;
  logic [ctwr_pkg::STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    cmd_o.step = step_q;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
        if (in_valid_i && status_i.in_op != ctwr_pkg::OP_NONE) begin
          state_d = S_RUN;
          step_d  = '0;
        end
      end
      S_RUN: begin
        // One cell write per cycle whenever the output register can take it.
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last) begin
            state_d = S_IDLE;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== rtl/ctwr_datapath.sv =====
// Datapath of the text console character writer: configuration registers,
// cursor, address arithmetic and the output register. Depends on ctwr_pkg.

module ctwr_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ctwr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ctwr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [ctwr_pkg::CHAR_W-1:0]         in_char_code_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [ctwr_pkg::ADDR_W-1:0]         out_cell_address_o,
  output logic [ctwr_pkg::CHAR_W-1:0]         out_cell_char_o,
  output logic [7:0]                          out_cell_attr_o,
  output logic                                out_out_of_range_o,
  output logic                                out_last_write_o,
  input  ctwr_pkg::cmd_t                      cmd_i,
  output ctwr_pkg::status_t                   status_o
);

  localparam int COL_W = ctwr_pkg::COL_W;
  localparam int ROW_W = ctwr_pkg::ROW_W;

  logic [COL_W-1:0] min_x_q, max_x_q, off_x_q;
  logic [ROW_W-1:0] min_y_q, max_y_q, off_y_q;
  logic [7:0]       attr_q;

  logic [COL_W-1:0]            col_q, col_d;
  logic [ROW_W-1:0]            row_q, row_d;
  ctwr_pkg::op_e               op_q;
  logic [ctwr_pkg::CHAR_W-1:0] char_q;
  logic [COL_W:0]              stop_q;

  logic                        out_valid_q;
  logic [ctwr_pkg::ADDR_W-1:0] addr_q;
  logic [ctwr_pkg::CHAR_W-1:0] ochar_q;
  logic [7:0]                  oattr_q;
  logic                        off_q, last_q;

  // Row clamp at the bottom of the printable area; the input may be one past 63.
  function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W:0] r,
                                                 input logic [ROW_W-1:0] max_y);
    logic [ROW_W-1:0] res;
    res = r[ROW_W-1:0];
    if (r >= {1'b0, max_y}) begin
      res = (max_y != '0) ? max_y - 1'b1 : '0;
    end
    return res;
  endfunction

  function automatic ctwr_pkg::op_e decode(input logic [ctwr_pkg::CHAR_W-1:0] c);
    ctwr_pkg::op_e op;
    op = ctwr_pkg::OP_PRINT;
    if (c == ctwr_pkg::CHAR_NUL || c == ctwr_pkg::CHAR_RETURN ||
        c == ctwr_pkg::CHAR_NEWLINE) begin
      op = ctwr_pkg::OP_NONE;
    end else if (c == ctwr_pkg::CHAR_BACKSPACE) begin
      op = ctwr_pkg::OP_BACK;
    end else if (c == ctwr_pkg::CHAR_TAB) begin
      op = ctwr_pkg::OP_TAB;
    end
    return op;
  endfunction

  // Cursor advance after a printed cell.
  logic [COL_W:0]   col_inc;
  logic [COL_W-1:0] adv_col;
  logic [ROW_W:0]   adv_row_raw;
  logic [ROW_W-1:0] adv_row;

  always_comb begin
    col_inc = {1'b0, col_q} + 1'b1;
    if (col_inc >= {1'b0, max_x_q}) begin
      adv_col     = min_x_q;
      adv_row_raw = {1'b0, row_q} + 1'b1;
    end else begin
      adv_col     = col_inc[COL_W-1:0];
      adv_row_raw = {1'b0, row_q};
    end
    adv_row = clamp_row(adv_row_raw, max_y_q);
  end

  // Cursor retreat for backspace.
  logic [COL_W-1:0] ret_col;
  logic [ROW_W-1:0] ret_row;

  always_comb begin
    ret_col = col_q;
    ret_row = row_q;
    if (col_q > min_x_q) begin
      ret_col = col_q - 1'b1;
    end else if (row_q > min_y_q) begin
      ret_row = row_q - 1'b1;
      ret_col = (max_x_q != '0) ? max_x_q - 1'b1 : '0;
    end
  end

  // Screen address of the current cursor cell.
  logic [COL_W:0]              scr_col;
  logic [ROW_W:0]              scr_row;
  logic                        scr_off;
  logic [ctwr_pkg::ADDR_W-1:0] scr_addr;

  always_comb begin
    scr_col  = {1'b0, col_q} + {1'b0, off_x_q};
    scr_row  = {1'b0, row_q} + {1'b0, off_y_q};
    scr_off  = (scr_col >= (COL_W+1)'(ctwr_pkg::SCREEN_COLUMNS)) ||
               (scr_row >= (ROW_W+1)'(ctwr_pkg::SCREEN_ROWS));
    scr_addr = ctwr_pkg::ADDR_W'(scr_col) +
               ctwr_pkg::ADDR_W'(scr_row) * ctwr_pkg::ADDR_W'(ctwr_pkg::SCREEN_COLUMNS);
  end

  // Whether the write being issued now ends this character.
  logic last;

  always_comb begin
    case (op_q)
      ctwr_pkg::OP_BACK: last = (cmd_i.step != '0);
      ctwr_pkg::OP_TAB: begin
        // A tab also ends when the advance wrapped back to a lower column.
        last = (adv_col <= col_q) || ({1'b0, adv_col} >= stop_q) ||
               (cmd_i.step == ctwr_pkg::STEP_W'(ctwr_pkg::MAX_RESULTS - 1));
      end
      default: last = 1'b1;
    endcase
  end

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.in_op    = decode(in_char_code_i);
  assign status_o.last     = last;
  assign status_o.out_free = out_free;

  // Cursor update.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.load) begin
      if (in_char_code_i == ctwr_pkg::CHAR_RETURN) begin
        col_d = min_x_q;
      end else if (in_char_code_i == ctwr_pkg::CHAR_NEWLINE) begin
        col_d = min_x_q;
        row_d = clamp_row({1'b0, row_q} + 1'b1, max_y_q);
      end
    end else if (cmd_i.emit) begin
      if (op_q == ctwr_pkg::OP_BACK) begin
        if (cmd_i.step == '0) begin
          col_d = ret_col;
          row_d = ret_row;
        end
      end else begin
        col_d = adv_col;
        row_d = adv_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= '0;
      min_y_q <= '0;
      max_x_q <= COL_W'(ctwr_pkg::SCREEN_COLUMNS);
      max_y_q <= ROW_W'(ctwr_pkg::SCREEN_ROWS);
      off_x_q <= '0;
      off_y_q <= '0;
      attr_q  <= 8'd7;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ctwr_pkg::CFG_AREA_MIN_X: min_x_q <= cfg_data_i[COL_W-1:0];
        ctwr_pkg::CFG_AREA_MIN_Y: min_y_q <= cfg_data_i[ROW_W-1:0];
        ctwr_pkg::CFG_AREA_MAX_X: max_x_q <= cfg_data_i[COL_W-1:0];
        ctwr_pkg::CFG_AREA_MAX_Y: max_y_q <= cfg_data_i[ROW_W-1:0];
        ctwr_pkg::CFG_OFFSET_X:   off_x_q <= cfg_data_i[COL_W-1:0];
        ctwr_pkg::CFG_OFFSET_Y:   off_y_q <= cfg_data_i[ROW_W-1:0];
        ctwr_pkg::CFG_ATTRIBUTE:  attr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      op_q        <= ctwr_pkg::OP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cmd_i.load) begin
        op_q <= decode(in_char_code_i);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      char_q <= in_char_code_i;
      stop_q <= ((COL_W+1)'(col_q / ctwr_pkg::TAB_WIDTH) + 1'b1) *
                (COL_W+1)'(ctwr_pkg::TAB_WIDTH);
    end
    if (cmd_i.emit) begin
      addr_q  <= scr_off ? '0 : scr_addr;
      off_q   <= scr_off;
      last_q  <= last;
      case (op_q)
        ctwr_pkg::OP_BACK: begin
          ochar_q <= '0;
          oattr_q <= '0;
        end
        ctwr_pkg::OP_TAB: begin
          ochar_q <= ctwr_pkg::CHAR_SPACE;
          oattr_q <= attr_q;
        end
        default: begin
          ochar_q <= char_q;
          oattr_q <= attr_q;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_cell_address_o = addr_q;
  assign out_cell_char_o    = ochar_q;
  assign out_cell_attr_o    = oattr_q;
  assign out_out_of_range_o = off_q;
  assign out_last_write_o   = last_q;

endmodule

// ===== rtl/text_console_char_writer_unit.sv =====
// Top level of the text console character writer.
// Depends on ctwr_pkg, ctwr_ctrl and ctwr_datapath.
//
// Usage: one character code is offered on in_char_code_i with in_valid_i and
// is taken at a clock edge where in_stall_o is low. Each character yields
// zero to four cell writes on the output channel, each presented with
// out_valid_o and taken when out_stall_i is low; out_last_write_o marks the
// final write of a character. Nul produces no item and leaves the cursor;
// return and newline only move the cursor and produce no item.
// Throughput: the character is registered when taken, then the write
// sequencer moves on to its run state and passes one cell write per cycle
// into the output register whenever that register is free, so the first
// write follows the registered character through the run state.
// While the receiver stalls, the output register holds its item and the
// sequencer waits; the input stays stalled until the character is done.
// Reset clears the cursor to the top left and loads the default area, a
// zero window offset and attribute 7. Configuration writes land at once and
// are expected only while the block is idle.

module text_console_char_writer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] out_cell_address_o,
  output logic [7:0]  out_cell_char_o,
  output logic [7:0]  out_cell_attr_o,
  output logic        out_out_of_range_o,
  output logic        out_last_write_o
);

  ctwr_pkg::cmd_t    cmd;
  ctwr_pkg::status_t status;

  ctwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ctwr_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_char_code_i     (in_char_code_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .out_cell_address_o (out_cell_address_o),
    .out_cell_char_o    (out_cell_char_o),
    .out_cell_attr_o    (out_cell_attr_o),
    .out_out_of_range_o (out_out_of_range_o),
    .out_last_write_o   (out_last_write_o),
    .cmd_i              (cmd),
    .status_o           (status)
  );

  // No cell write is issued while a new character may be taken.
  a_no_emit_when_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !cmd.emit)
    else $error("cell write issued while input is open");

  // A write is only issued into a free output register.
  a_emit_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || !out_stall_i))
    else $error("cell write overran a waiting item");

  // The final write of a character reopens the input on the next cycle.
  a_last_reopens_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && status.last) |=> (!in_stall_o && out_valid_o && out_last_write_o))
    else $error("input not reopened after final write");

  // Off-screen writes carry a zero address.
  a_off_screen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_out_of_range_o) |-> (out_cell_address_o == 12'd0))
    else $error("off-screen write with non-zero address");

endmodule

// ===== tb/sv/tb_text_console_char_writer_unit.sv =====
// Self-checking testbench for text_console_char_writer_unit: directed and random characters
// under changing window settings, with every cell write checked against a cursor tracker.
// Depends on ctwr_pkg and the block itself.

module tb_text_console_char_writer_unit;
  import ctwr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    bit [ADDR_W-1:0] cell_address;
    bit [CHAR_W-1:0] cell_char;
    bit [7:0]        cell_attr;
    bit              out_of_range;
    bit              last_write;
  } cell_write_t;

  // Tracks the cursor and window settings and keeps the cell writes still owed by the block.
  class cursor_cell_book;
    bit [COL_W-1:0] min_x, max_x, off_x, col;
    bit [ROW_W-1:0] min_y, max_y, off_y, row;
    bit [7:0]       attr;
    cell_write_t    cells_due[$];
    int             mismatches;

    function new();
      min_x = 0; min_y = 0; max_x = 80; max_y = 50;
      off_x = 0; off_y = 0; attr = 8'd7;
      col = 0; row = 0;
      mismatches = 0;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_AREA_MIN_X: min_x = data[COL_W-1:0];
        CFG_AREA_MIN_Y: min_y = data[ROW_W-1:0];
        CFG_AREA_MAX_X: max_x = data[COL_W-1:0];
        CFG_AREA_MAX_Y: max_y = data[ROW_W-1:0];
        CFG_OFFSET_X:   off_x = data[COL_W-1:0];
        CFG_OFFSET_Y:   off_y = data[ROW_W-1:0];
        CFG_ATTRIBUTE:  attr  = data;
        default: ;
      endcase
    endfunction

    function void push_cell(bit [CHAR_W-1:0] ch, bit [7:0] at);
      int unsigned c, r;
      cell_write_t w;
      c = col + off_x;
      r = row + off_y;
      w.out_of_range = (c >= SCREEN_COLUMNS) || (r >= SCREEN_ROWS);
      w.cell_address = w.out_of_range ? '0 : ADDR_W'(c + r * SCREEN_COLUMNS);
      w.cell_char    = ch;
      w.cell_attr    = at;
      w.last_write   = 1'b0;
      cells_due.push_back(w);
    endfunction

    // A row past the bottom of the area sticks to the last row, or to row 0 if the area is empty.
    function void settle_row(int unsigned r);
      if (r >= max_y) r = (max_y != 0) ? max_y - 1 : 0;
      row = r[ROW_W-1:0];
    endfunction

    function void step_forward();
      int unsigned c, r;
      c = col + 1;
      r = row;
      if (c >= max_x) begin
        c = min_x;
        r = r + 1;
      end
      col = c[COL_W-1:0];
      settle_row(r);
    endfunction

    function void step_back();
      if (col > min_x) begin
        col = col - 1'b1;
      end else if (row > min_y) begin
        row = row - 1'b1;
        col = (max_x != '0) ? max_x - 1'b1 : '0;
      end
    endfunction

    function void take_char(bit [CHAR_W-1:0] code);
      int unsigned   stop;
      int            first;
      bit [COL_W-1:0] was;
      bit            wrapped;
      cell_write_t   w;
      first   = cells_due.size();
      wrapped = 1'b0;
      case (code)
        CHAR_NUL: ;
        CHAR_RETURN: col = min_x;
        CHAR_NEWLINE: begin
          settle_row(row + 1);
          col = min_x;
        end
        CHAR_BACKSPACE: begin
          push_cell(CHAR_NUL, 8'd0);
          step_back();
          push_cell(CHAR_NUL, 8'd0);
        end
        CHAR_TAB: begin
          stop = (col / TAB_WIDTH + 1) * TAB_WIDTH;
          // A wrap onto a lower column ends the tab even short of the stop.
          while (!wrapped && col < stop && (cells_due.size() - first) < MAX_RESULTS) begin
            was = col;
            push_cell(CHAR_SPACE, attr);
            step_forward();
            wrapped = (col <= was);
          end
        end
        default: begin
          push_cell(code, attr);
          step_forward();
        end
      endcase
      if (cells_due.size() > first) begin
        w = cells_due.pop_back();
        w.last_write = 1'b1;
        cells_due.push_back(w);
      end
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_field(string name, int unsigned got, int unsigned want);
      if (got != want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task match_cell(cell_write_t got);
      cell_write_t want;
      if (cells_due.size() == 0) begin
        report_mismatch($sformatf("cell write to %0d with none expected", got.cell_address));
      end else begin
        want = cells_due.pop_front();
        check_field("cell_address", got.cell_address, want.cell_address);
        check_field("cell_char", got.cell_char, want.cell_char);
        check_field("cell_attr", got.cell_attr, want.cell_attr);
        check_field("out_of_range", got.out_of_range, want.out_of_range);
        check_field("last_write", got.last_write, want.last_write);
      end
    endtask

    task close_out();
      if (cells_due.size() != 0)
        report_mismatch($sformatf("%0d cell writes never arrived", cells_due.size()));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [2:0]        cfg_index;
  logic [7:0]        cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_char_code;
  logic              out_valid;
  logic              out_stall;
  logic [11:0]       out_cell_address;
  logic [7:0]        out_cell_char;
  logic [7:0]        out_cell_attr;
  logic              out_out_of_range;
  logic              out_last_write;

  cursor_cell_book   cells;
  int unsigned       idle_cycles;
  bit [15:0]         stall_clock;
  bit [CHAR_W-1:0]   script[$];

  text_console_char_writer_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .in_char_code_i     (in_char_code),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .out_cell_address_o (out_cell_address),
    .out_cell_char_o    (out_cell_char),
    .out_cell_attr_o    (out_cell_attr),
    .out_out_of_range_o (out_out_of_range),
    .out_last_write_o   (out_last_write)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Checks each accepted cell write, drives the receiver's stall and watches for a hang.
  always @(posedge clk_i) begin : watch_outputs
    cell_write_t seen;
    if (out_valid && !out_stall) begin
      seen.cell_address = out_cell_address;
      seen.cell_char    = out_cell_char;
      seen.cell_attr    = out_cell_attr;
      seen.out_of_range = out_out_of_range;
      seen.last_write   = out_last_write;
      cells.match_cell(seen);
    end
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
    stall_clock <= stall_clock + 16'd1;
    // The stall style, set by bits 8:7 of the stall clock, runs through none, light, heavy, then a fixed beat.
    case (stall_clock[8:7])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_clock[2];
    endcase
  end

  task automatic write_reg(input bit [CFG_IDX_W-1:0] idx, input bit [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    cells.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_window(input int unsigned nx, ny, mx, my, ox, oy, at);
    write_reg(CFG_AREA_MIN_X, nx[7:0]);
    write_reg(CFG_AREA_MIN_Y, ny[7:0]);
    write_reg(CFG_AREA_MAX_X, mx[7:0]);
    write_reg(CFG_AREA_MAX_Y, my[7:0]);
    write_reg(CFG_OFFSET_X, ox[7:0]);
    write_reg(CFG_OFFSET_Y, oy[7:0]);
    write_reg(CFG_ATTRIBUTE, at[7:0]);
  endtask

  task automatic random_window();
    int unsigned nx, ny, mx, my, ox, oy;
    mx = $urandom_range(1, 80);
    my = $urandom_range(1, 50);
    nx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 80) : $urandom_range(0, mx - 1);
    ny = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 50) : $urandom_range(0, my - 1);
    ox = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 79) : $urandom_range(0, 10);
    oy = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 49) : $urandom_range(0, 10);
    load_window(nx, ny, mx, my, ox, oy, $urandom_range(0, 255));
  endtask

  // Valid stays high after acceptance unless a gap follows, so back-to-back items need no toggle.
  task automatic send_char(input bit [CHAR_W-1:0] code, input int unsigned gap);
    in_valid     <= 1'b1;
    in_char_code <= code;
    do @(posedge clk_i); while (in_stall);
    cells.take_char(code);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    while (cells.cells_due.size() != 0) @(posedge clk_i);
  endtask

  // Called with the sender idle; lets a character with no writes finish before settings change.
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic play_script();
    foreach (script[i]) send_char(script[i], $urandom_range(0, 3));
    in_valid <= 1'b0;
  endtask

  function automatic bit [CHAR_W-1:0] pick_char();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return CHAR_BACKSPACE;
    if (roll < 20) return CHAR_TAB;
    if (roll < 26) return CHAR_NEWLINE;
    if (roll < 31) return CHAR_RETURN;
    if (roll < 34) return CHAR_NUL;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  task automatic run_random(input int unsigned count, input bit steady);
    int unsigned     counted, burst_left, gap;
    bit              paused;
    bit [CHAR_W-1:0] code;
    counted    = 0;
    paused     = 1'b0;
    burst_left = $urandom_range(1, 12);
    while (counted < count) begin
      code = pick_char();
      burst_left--;
      gap = (burst_left == 0 && !steady) ? $urandom_range(1, 8) : 0;
      if (burst_left == 0) burst_left = $urandom_range(1, 12);
      send_char(code, gap);
      if (code != CHAR_NUL) counted++;
      // Midway the sender holds off until the block has delivered everything owed.
      if (!paused && counted >= count / 2) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk_i);
        drain();
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    cells        = new();
    idle_cycles  = 0;
    stall_clock  = 0;
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_AREA_MIN_X;
    cfg_data     <= 8'd0;
    in_valid     <= 1'b0;
    in_char_code <= CHAR_NUL;
    out_stall    <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: printable extremes, tabs to the next stop, backspace at the origin.
    script = '{8'hFF, 8'h01, CHAR_TAB, CHAR_TAB, CHAR_RETURN, CHAR_BACKSPACE, CHAR_NUL,
               CHAR_NEWLINE, 8'h41};
    play_script();
    settle();

    // Narrow area at the right edge: bottom clamp, tab wrap, backspace up a row.
    load_window(76, 0, 80, 3, 0, 0, 8'h1F);
    script = '{CHAR_NEWLINE, CHAR_NEWLINE, CHAR_NEWLINE, CHAR_TAB, 8'h78, CHAR_BACKSPACE,
               CHAR_BACKSPACE, CHAR_TAB};
    play_script();
    settle();

    // Offsets that put the cursor on the last screen cell, then one step off screen.
    load_window(0, 0, 80, 50, 79, 49 - cells.row, 255);
    write_reg(CFG_SPARE, 8'hA5);
    script = '{CHAR_RETURN, 8'h71, 8'h72};
    play_script();
    settle();

    // Inverted area bounds at their extremes.
    load_window(80, 50, 1, 1, 0, 0, 0);
    script = '{8'h6D, CHAR_TAB, CHAR_BACKSPACE};
    play_script();
    settle();

    repeat (3) begin
      random_window();
      run_random(30, 1'b0);
      settle();
    end
    load_window(0, 0, 80, 50, 0, 0, 7);
    run_random(30, 1'b1);
    settle();
    random_window();
    run_random(30, 1'b0);

    settle();
    cells.close_out();
    if (cells.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ctwr_pkg.sv
rtl/ctwr_ctrl.sv
rtl/ctwr_datapath.sv
rtl/text_console_char_writer_unit.sv
tb/sv/tb_text_console_char_writer_unit.sv
